// File: rtl/sepq_pkg.sv
// Shared types and codes for the sorted event priority queue.
package sepq_pkg;

  // One stored event
  typedef struct packed {
    logic [31:0] time_val;
    logic [15:0] prio;
    logic [15:0] job;
    logic [31:0] id;
  } entry_t;

  // Command codes on action_i
  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_NONE_DUE   = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PLACE = 4'b0100,
    S_POP   = 4'b1000
  } state_e;

endpackage

// File: rtl/sorted_event_priority_queue.sv
// Top level of the sorted event priority queue: control, pointers and result register.
//
// Events live in a circular buffer in one memory, kept sorted by time, then higher
// priority, then newest first; the head is always the next event to dispatch. A
// command is taken when start_i is high and busy_o is low; its result appears on
// the result ports for one cycle with done_o high, and must be taken then. A
// dispatch reads the head and pops it only if its time is not after stop_time.
// An insert into an empty or a full queue and a dispatch on an empty queue answer
// from the idle state. An insert into a non-empty queue walks back from the tail
// through the memory's single read port, moving one entry up per cycle for each
// stored event that sorts after the new one, until it reaches the insertion point.
// busy_o is low again in the cycle in which the result is shown, so the next
// command may be given then. stop_time is written through cfg_we_i / cfg_wdata_i;
// the user must do so only while the block is idle; the block does not enforce it.
module sorted_event_priority_queue import sepq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [31:0] event_time_i,
  input  logic [15:0] priority_req_i,
  input  logic [15:0] job_handle_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_job_handle_o,
  output logic [31:0] out_event_time_o,
  output logic [31:0] out_event_id_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_e          state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     next_id_q, next_id_d;
  logic [31:0]     stop_time_q;
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q;
  logic [CW-1:0]   left_q, left_d;
  entry_t          new_q, new_d;

  logic            done_q, done_d;
  logic [1:0]      status_q, status_d;
  logic [15:0]     job_q, job_d;
  logic [31:0]     time_q, time_d;
  logic [31:0]     id_q, id_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  logic [AW:0]     tail_sum;
  logic [AW-1:0]   tail;
  logic            after_new;
  logic            accept;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_A : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + 1'b1;
  endfunction

  sepq_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Physical slot just past the last stored entry
  assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];

  // Entry just read sorts after the pending new event
  assign after_new = (mem_rdata.time_val > new_q.time_val) ||
                     ((mem_rdata.time_val == new_q.time_val) &&
                      (mem_rdata.prio <= new_q.prio));

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Sequence commands and drive the memory
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    next_id_d = next_id_q;
    wr_ptr_d  = wr_ptr_q;
    left_d    = left_q;
    new_d     = new_q;
    done_d    = 1'b0;
    status_d  = status_q;
    job_d     = job_q;
    time_d    = time_q;
    id_d      = id_q;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = new_q;
    mem_raddr = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept && action_i == ACT_INSERT) begin
          if (count_q == DEPTH_C) begin
            done_d   = 1'b1;
            status_d = ST_FULL;
            job_d    = '0;
            time_d   = '0;
            id_d     = '0;
          end else begin
            new_d     = '{time_val: event_time_i, prio: priority_req_i,
                          job: job_handle_i, id: next_id_q};
            next_id_d = next_id_q + 32'd1;
            if (count_q == '0) begin
              // Empty queue: store at once
              mem_we    = 1'b1;
              mem_waddr = tail;
              mem_wdata = new_d;
              count_d   = count_q + 1'b1;
              done_d    = 1'b1;
              status_d  = ST_INSERTED;
              job_d     = '0;
              time_d    = '0;
              id_d      = next_id_q;
            end else begin
              mem_raddr = ptr_dec(tail);
              wr_ptr_d  = tail;
              left_d    = count_q;
              state_d   = S_SCAN;
            end
          end
        end else if (accept) begin
          if (count_q == '0) begin
            done_d   = 1'b1;
            status_d = ST_NONE_DUE;
            job_d    = '0;
            time_d   = '0;
            id_d     = '0;
          end else begin
            mem_raddr = head_q;
            state_d   = S_POP;
          end
        end
      end

      S_SCAN: begin
        if (after_new) begin
          // Move the entry up one slot and keep walking back
          mem_we    = 1'b1;
          mem_waddr = wr_ptr_q;
          mem_wdata = mem_rdata;
          wr_ptr_d  = rd_ptr_q;
          left_d    = left_q - 1'b1;
          mem_raddr = ptr_dec(rd_ptr_q);
          if (left_q == CW'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          // Insertion point found
          mem_we   = 1'b1;
          count_d  = count_q + 1'b1;
          done_d   = 1'b1;
          status_d = ST_INSERTED;
          job_d    = '0;
          time_d   = '0;
          id_d     = new_q.id;
          state_d  = S_IDLE;
        end
      end

      S_PLACE: begin
        // New event becomes the head
        mem_we   = 1'b1;
        count_d  = count_q + 1'b1;
        done_d   = 1'b1;
        status_d = ST_INSERTED;
        job_d    = '0;
        time_d   = '0;
        id_d     = new_q.id;
        state_d  = S_IDLE;
      end

      S_POP: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (mem_rdata.time_val > stop_time_q) begin
          status_d = ST_NONE_DUE;
          job_d    = '0;
          time_d   = '0;
          id_d     = '0;
        end else begin
          status_d = ST_DISPATCHED;
          job_d    = mem_rdata.job;
          time_d   = mem_rdata.time_val;
          id_d     = mem_rdata.id;
          head_d   = ptr_inc(head_q);
          count_d  = count_q - 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      next_id_q   <= '0;
      stop_time_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        stop_time_q <= cfg_wdata_i;
      end
    end
  end

  // Walk pointers, pending event and result beat
  always_ff @(posedge clk_i) begin
    wr_ptr_q <= wr_ptr_d;
    rd_ptr_q <= mem_raddr;
    left_q   <= left_d;
    new_q    <= new_d;
    status_q <= status_d;
    job_q    <= job_d;
    time_q   <= time_d;
    id_q     <= id_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_job_handle_o = job_q;
  assign out_event_time_o = time_q;
  assign out_event_id_o   = id_q;

endmodule

// File: rtl/sepq_ram.sv
// Entry memory: one write port, one read port, registered read data.
module sepq_ram import sepq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
